// File: hdl/tcfifo_pkg.sv
// ---------------------------------------------------------------------------
// tcfifo_pkg
// Shared types and constants for the two-class oldest-first queue.
// ---------------------------------------------------------------------------
package tcfifo_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_W_DEF        = 16;
  localparam int STAMP_W         = 6;

  typedef enum logic [1:0] {
    OP_ENQ     = 2'd0,
    OP_DEQ_ANY = 2'd1,
    OP_DEQ_C1  = 2'd2,
    OP_DEQ_C0  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED  = 2'd0,
    ST_DELIVERED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_DROPPED   = 2'd3
  } status_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// File: hdl/two_class_age_ordered_fifo_core.sv
// ---------------------------------------------------------------------------
// two_class_age_ordered_fifo_core
// Two class queues with oldest-first service across classes.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: enqueue,
//   dequeue oldest of either class, dequeue class 1 or dequeue class 0.
//   Result channel (out_valid/out_ready) returns exactly one word per
//   command: status, delivered identifier and its class.
//   Each enqueued word is tagged with a 6-bit arrival stamp; an "any"
//   dequeue compares the two head stamps modulo 64.
//   A command accepted into the input register is executed from there; its
//   result is written into the result register, which drives the result port.
//   Throughput: one command per cycle while results are taken; the head
//   of each queue is read ahead from its RAM so back-to-back pops never wait.
//   A stalled receiver holds the result register; one more command waits
//   in the input register, then in_ready drops until out_ready returns.
//   Reset (rst_n low, synchronous) empties both queues and clears the
//   stamp; RAM contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module two_class_age_ordered_fifo_core #(
  parameter int QUEUE_DEPTH = tcfifo_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = tcfifo_pkg::ID_W_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  input  logic [ID_WIDTH-1:0] in_item_id,
  input  logic                in_item_class,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [ID_WIDTH-1:0] out_id,
  output logic                out_class
);
  import tcfifo_pkg::*;

  localparam int ENTRY_W = STAMP_W + ID_WIDTH;

  // input register
  logic                in_valid_r;
  op_t                 op_r;
  logic [ID_WIDTH-1:0] item_id_r;
  logic                item_class_r;

  // result register
  logic                out_valid_r;
  status_t             status_r, status_nxt;
  logic [ID_WIDTH-1:0] out_id_r, out_id_nxt;
  logic                out_class_r, out_class_nxt;

  logic [STAMP_W-1:0]  stamp_r, stamp_nxt;
  logic                adv;

  // queue interface
  logic               push0, push1, pop0, pop1;
  logic [ENTRY_W-1:0] push_data;
  logic [ENTRY_W-1:0] head0, head1;
  q_status_t          qs0, qs1;

  logic [STAMP_W-1:0] stamp_diff;
  logic               older0;
  logic               sel_cls;
  logic               deq;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      op_r         <= op_t'(in_operation);
      item_id_r    <= in_item_id;
      item_class_r <= in_item_class;
    end
  end

  // wrap-aware age compare of the two heads
  assign stamp_diff = head0[ID_WIDTH +: STAMP_W] - head1[ID_WIDTH +: STAMP_W];
  assign older0     = stamp_diff[STAMP_W-1];
  assign push_data  = {stamp_r, item_id_r};

  // command execution
  always_comb begin
    push0         = 1'b0;
    push1         = 1'b0;
    pop0          = 1'b0;
    pop1          = 1'b0;
    deq           = 1'b0;
    sel_cls       = 1'b0;
    stamp_nxt     = stamp_r;
    status_nxt    = ST_EMPTY;
    out_id_nxt    = '0;
    out_class_nxt = 1'b0;
    case (op_r)
      OP_ENQ: begin
        if (item_class_r ? qs1.full : qs0.full) begin
          status_nxt = ST_DROPPED;
        end else begin
          push0      = adv && !item_class_r;
          push1      = adv && item_class_r;
          stamp_nxt  = stamp_r + 1'b1;
          status_nxt = ST_ENQUEUED;
        end
      end
      OP_DEQ_ANY: begin
        deq = 1'b1;
        if (!qs0.empty && !qs1.empty) begin
          sel_cls = !older0;
        end else begin
          sel_cls = qs0.empty;
        end
      end
      OP_DEQ_C1: begin
        deq     = 1'b1;
        sel_cls = 1'b1;
      end
      OP_DEQ_C0: begin
        deq     = 1'b1;
        sel_cls = 1'b0;
      end
      default: begin
        deq = 1'b0;
      end
    endcase
    // shared delivery path
    if (deq && !(sel_cls ? qs1.empty : qs0.empty)) begin
      pop0          = adv && !sel_cls;
      pop1          = adv && sel_cls;
      status_nxt    = ST_DELIVERED;
      out_id_nxt    = sel_cls ? head1[ID_WIDTH-1:0] : head0[ID_WIDTH-1:0];
      out_class_nxt = sel_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      stamp_r     <= stamp_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r    <= status_nxt;
      out_id_r    <= out_id_nxt;
      out_class_r <= out_class_nxt;
    end
  end

  tcfifo_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_queue0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push0),
    .push_data (push_data),
    .pop       (pop0),
    .head_data (head0),
    .status    (qs0)
  );

  tcfifo_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_queue1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push1),
    .push_data (push_data),
    .pop       (pop1),
    .head_data (head1),
    .status    (qs1)
  );

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_id     = out_id_r;
  assign out_class  = out_class_r;

`ifndef ASSERT_OFF
  // the stamp moves only on an enqueue that was stored
  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (push0 || push1)) |=> (stamp_r == $past(stamp_r) + 1'b1))
    else $error("arrival stamp did not advance on a stored enqueue");

  a_stamp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!(adv && (push0 || push1))) |=> $stable(stamp_r))
    else $error("arrival stamp changed without a stored enqueue");

  // only delivered words carry an identifier and class
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_DELIVERED)) |-> (out_id_r == '0 && !out_class_r))
    else $error("non-delivery result carries payload");

  // at most one queue changes per command
  a_one_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({push0, push1, pop0, pop1}) <= 1)
    else $error("more than one queue operation in one cycle");
`endif

endmodule

// File: hdl/tcfifo_ram.sv
// ---------------------------------------------------------------------------
// tcfifo_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tcfifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/tcfifo_queue.sv
// ---------------------------------------------------------------------------
// tcfifo_queue
// One class queue: RAM storage, head/tail pointers, count and a head word
// from the read port (read-ahead on the next head) or the bypass register.
// ---------------------------------------------------------------------------
module tcfifo_queue #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 22
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      head_data,
  output tcfifo_pkg::q_status_t status
);
  import tcfifo_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             byp_valid_r;
  logic [WIDTH-1:0] byp_data_r;
  logic [WIDTH-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // pointer and count update
  always_comb begin
    head_nxt  = pop  ? next_slot(head_r) : head_r;
    tail_nxt  = push ? next_slot(tail_r) : tail_r;
    count_nxt = count_r;
    if (push) begin
      count_nxt = count_r + 1'b1;
    end else if (pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      byp_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      byp_valid_r <= push && (tail_r == head_nxt);
    end
  end

  // write into the slot the head reads next: forward the word
  always_ff @(posedge clk) begin
    byp_data_r <= push_data;
  end

  tcfifo_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail_r),
    .wdata (push_data),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  assign head_data    = byp_valid_r ? byp_data_r : ram_rdata;
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CNT_W'(DEPTH));

endmodule

// File: tb/tb_two_class_age_ordered_fifo_core.sv
// ---------------------------------------------------------------------------
// tb_two_class_age_ordered_fifo_core
// Self-checking bench for the two-class oldest-first queue. Command words are
// sent with random gaps and results are taken with random stalls. A
// scoreboard keeps its own copy of both class queues and the arrival stamp,
// predicts one result per accepted command and checks the results in order.
// ---------------------------------------------------------------------------
module tb_two_class_age_ordered_fifo_core;
  import tcfifo_pkg::*;

  localparam int DEPTH          = QUEUE_DEPTH_DEF;
  localparam int IDW            = ID_W_DEF;
  localparam int RANDOM_WORDS   = 480;
  localparam int MAX_IDLE       = 17;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  // predicts and checks results of the queue pair
  class tcfifo_scoreboard;
    typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [IDW-1:0]     id;
    } slot_t;

    typedef struct packed {
      status_t        status;
      logic [IDW-1:0] id;
      logic           cls;
    } reply_t;

    slot_t              held[2][$];
    reply_t             due_replies[$];
    logic [STAMP_W-1:0] stamp_ctr;
    int                 errors;
    int                 words_in;
    int                 replies;
    int                 n_delivered;
    int                 n_empty;
    int                 n_dropped;

    function new();
      stamp_ctr   = '0;
      errors      = 0;
      words_in    = 0;
      replies     = 0;
      n_delivered = 0;
      n_empty     = 0;
      n_dropped   = 0;
    endfunction

    // pop the head of one class lane, or report it empty
    function reply_t serve_lane(int lane);
      reply_t r;
      slot_t  s;
      r.status = ST_EMPTY;
      r.id     = '0;
      r.cls    = 1'b0;
      if (held[lane].size() != 0) begin
        s        = held[lane].pop_front();
        r.status = ST_DELIVERED;
        r.id     = s.id;
        r.cls    = lane[0];
        n_delivered++;
      end else begin
        n_empty++;
      end
      return r;
    endfunction

    // apply one accepted command word and queue its expected result
    function void take_command(logic [1:0] op, logic [IDW-1:0] id, logic cls);
      reply_t             r;
      logic [STAMP_W-1:0] age_gap;
      r.status = ST_ENQUEUED;
      r.id     = '0;
      r.cls    = 1'b0;
      words_in++;
      case (op)
        OP_ENQ: begin
          if (held[cls].size() >= DEPTH) begin
            r.status = ST_DROPPED;
            n_dropped++;
          end else begin
            held[cls].push_back(slot_t'({stamp_ctr, id}));
            stamp_ctr++;
          end
        end
        OP_DEQ_C1: r = serve_lane(1);
        OP_DEQ_C0: r = serve_lane(0);
        OP_DEQ_ANY: begin
          // wrap-aware age compare of the two heads
          if (held[0].size() != 0 && held[1].size() != 0) begin
            age_gap = held[0][0].stamp - held[1][0].stamp;
            r = serve_lane(age_gap[STAMP_W-1] ? 0 : 1);
          end else begin
            r = serve_lane(held[0].size() != 0 ? 0 : 1);
          end
        end
        default: begin
          r.status = ST_ENQUEUED;
        end
      endcase
      due_replies.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // compare one result word with the oldest expectation
    task match_reply(logic [1:0] status, logic [IDW-1:0] id, logic cls);
      reply_t e;
      replies++;
      if (due_replies.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d id %h class %0d",
                                  status, id, cls));
        return;
      end
      e = due_replies.pop_front();
      if (status !== e.status)
        report_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                  replies, status, e.status));
      if (id !== e.id)
        report_mismatch($sformatf("result %0d id %h, predicted %h", replies, id, e.id));
      if (cls !== e.cls)
        report_mismatch($sformatf("result %0d class %0d, predicted %0d",
                                  replies, cls, e.cls));
    endtask
  endclass

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [1:0]     in_operation = OP_ENQ;
  logic [IDW-1:0] in_item_id = '0;
  logic           in_item_class = 1'b0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [1:0]     out_status;
  logic [IDW-1:0] out_id;
  logic           out_class;

  bit               in_burst = 1'b0;
  int               idle_cycles = 0;
  tcfifo_scoreboard sb = new();

  two_class_age_ordered_fifo_core #(
    .QUEUE_DEPTH(DEPTH),
    .ID_WIDTH   (IDW)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_item_id   (in_item_id),
    .in_item_class(in_item_class),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_id       (out_id),
    .out_class    (out_class)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // send one command word after a random gap, return at the accepting edge
  task automatic send_word(input logic [1:0] op, input logic [IDW-1:0] id,
                           input logic cls);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_item_id    <= id;
    in_item_class <= cls;
    do @(posedge clk); while (!in_ready);
  endtask

  // dequeue with don't-care id and class
  task automatic send_dequeue(input logic [1:0] op);
    send_word(op, IDW'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  // random word stream in chunks with a shifting enqueue rate and class skew
  task automatic send_random_words();
    int             chunk_left;
    int             enq_pct;
    int             class1_pct;
    logic [1:0]     op;
    logic [IDW-1:0] id;
    chunk_left = 0;
    enq_pct    = 50;
    class1_pct = 50;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (chunk_left == 0) begin
        chunk_left = $urandom_range(20, 60);
        in_burst   = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
          0: enq_pct = 15;
          1: enq_pct = 50;
          2: enq_pct = 85;
          default: enq_pct = 97;
        endcase
        case ($urandom_range(0, 2))
          0: class1_pct = 10;
          1: class1_pct = 50;
          default: class1_pct = 90;
        endcase
      end
      chunk_left--;
      if ($urandom_range(0, 99) < enq_pct) begin
        case ($urandom_range(0, 9))
          0: id = '0;
          1: id = '1;
          default: id = IDW'($urandom_range(0, 65535));
        endcase
        send_word(OP_ENQ, id, ($urandom_range(0, 99) < class1_pct));
      end else begin
        case ($urandom_range(0, 2))
          0: op = OP_DEQ_ANY;
          1: op = OP_DEQ_C1;
          default: op = OP_DEQ_C0;
        endcase
        send_dequeue(op);
      end
    end
  endtask

  // result side: random stall before each word, with stall-free stretches
  initial begin
    int stall;
    int left;
    bit burst;
    left  = 0;
    burst = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (left == 0) begin
        left  = $urandom_range(10, 60);
        burst = ($urandom_range(0, 3) == 0);
      end
      left--;
      stall = burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // observe both handshakes and guard against a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_command(in_operation, in_item_id, in_item_class);
      if (out_valid && out_ready) sb.match_reply(out_status, out_id, out_class);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue on every dequeue flavor
    send_dequeue(OP_DEQ_ANY);
    send_dequeue(OP_DEQ_C0);
    send_dequeue(OP_DEQ_C1);
    // class 1 older, then class 0 alone
    send_word(OP_ENQ, '0, 1'b1);
    send_word(OP_ENQ, '1, 1'b0);
    send_dequeue(OP_DEQ_ANY);
    send_dequeue(OP_DEQ_ANY);
    // class 0 older; the class 1 word stays queued
    send_word(OP_ENQ, IDW'(16'ha5a5), 1'b0);
    send_word(OP_ENQ, IDW'(16'h5a5a), 1'b1);
    send_dequeue(OP_DEQ_ANY);
    // fill class 1 and overflow it by one
    for (int k = 0; k < DEPTH; k++) send_word(OP_ENQ, IDW'(16'h0100 + k), 1'b1);

    send_random_words();
    in_valid <= 1'b0;

    // drain outstanding results
    @(posedge clk);
    while (sb.due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.due_replies.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.due_replies.size()));

    $display("covered %0d command words and %0d results", sb.words_in, sb.replies);
    $display("results: %0d delivered, %0d empty, %0d dropped on full, %0d mismatches",
             sb.n_delivered, sb.n_empty, sb.n_dropped, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
